>>> src/nidf_pkg.sv
// ---------------------------------------------------------------------------
// nidf_pkg: shared constants, types and functions
// Widths, fixed-point formats and the elaboration-time log2 of the corpus size
// for the normalized inverse document frequency pipeline.
// ---------------------------------------------------------------------------
package nidf_pkg;

  // result format
  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = FRAC_BITS + 1;
  localparam int QBITS     = FRAC_BITS + 1;

  // input and product widths
  localparam int IN_W     = 64;
  localparam int CORPUS_W = 20;
  localparam logic [CORPUS_W-1:0] CORPUS_N = CORPUS_W'(1000000);
  localparam int PROD_W   = IN_W + CORPUS_W;

  // log2 format: msb position in the integer part, LOG_FRAC fraction bits
  localparam int LOG_FRAC = 40;
  localparam int POS_W    = 7;
  localparam int LOG_W    = POS_W + LOG_FRAC;
  localparam int MANT_W   = 64;
  localparam int HALF_W   = MANT_W / 2;

  // pipeline depths
  localparam int NORM_STAGES = 4;
  localparam int LOG_LAT     = NORM_STAGES + 2 * LOG_FRAC;
  localparam int DIV_STEPS   = 3;
  localparam int DIV_STAGES  = (QBITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int REM_W       = LOG_W + 1;

  // special results
  localparam logic [OUT_W-1:0] ONE_FIX  = OUT_W'(1) << FRAC_BITS;
  localparam logic [OUT_W-1:0] HALF_FIX = OUT_W'(1) << (FRAC_BITS - 1);

  // per-item flags that ride beside the log lanes
  typedef struct packed {
    logic valid;
    logic half;
    logic one;
  } nidf_side_t;

  // log2 of a nonzero value, same algorithm as the hardware lanes
  function automatic logic [LOG_W-1:0] log2_const(input logic [PROD_W-1:0] x);
    logic [POS_W-1:0]      pos;
    logic [PROD_W-1:0]     sh;
    logic [MANT_W-1:0]     m;
    logic [2*MANT_W-1:0]   sq;
    logic [LOG_FRAC-1:0]   frac;
    pos  = '0;
    frac = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (x[i]) pos = POS_W'(i);
    end
    sh = x << (POS_W'(PROD_W - 1) - pos);
    m  = sh[PROD_W-1 -: MANT_W];
    for (int i = 0; i < LOG_FRAC; i++) begin
      sq   = (2*MANT_W)'(m) * (2*MANT_W)'(m);
      frac = {frac[LOG_FRAC-2:0], sq[2*MANT_W-1]};
      if (sq[2*MANT_W-1]) begin
        m = sq[2*MANT_W-1 -: MANT_W];
      end else begin
        m = sq[2*MANT_W-2 -: MANT_W];
      end
    end
    return {pos, frac};
  endfunction

  localparam logic [LOG_W-1:0] LOG_N   = log2_const(PROD_W'(CORPUS_N));
  localparam logic [REM_W-1:0] DIVISOR = {LOG_N, 1'b0};

endpackage

>>> src/nidf_front.sv
// ---------------------------------------------------------------------------
// nidf_front: scaled product and special-case flags
// Forms doc_frequency * 1e6 from two narrow partial products and flags the
// zero-count, ratio-at-least-one-million and ratio-at-most-one cases.
// ---------------------------------------------------------------------------
module nidf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [nidf_pkg::IN_W-1:0]  doc_frequency,
  input  logic [nidf_pkg::IN_W-1:0]  doc_count,
  output nidf_pkg::nidf_side_t       side,
  output logic [nidf_pkg::PROD_W-1:0] prod,
  output logic [nidf_pkg::PROD_W-1:0] cnt
);
  import nidf_pkg::*;

  localparam int PP_W = HALF_W + CORPUS_W;

  logic              v1, v2;
  logic [PP_W-1:0]   pl1, ph1;
  logic [IN_W-1:0]   cnt1, cnt2;
  logic              half1, half2;
  logic [PROD_W-1:0] prod2;

  // stage 1: partial products and compares on the raw inputs
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    pl1   <= PP_W'(doc_frequency[HALF_W-1:0]) * PP_W'(CORPUS_N);
    ph1   <= PP_W'(doc_frequency[IN_W-1:HALF_W]) * PP_W'(CORPUS_N);
    cnt1  <= doc_count;
    half1 <= (doc_count == '0) || (doc_frequency >= doc_count);
  end

  // stage 2: sum the partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    prod2 <= (PROD_W'(ph1) << HALF_W) + PROD_W'(pl1);
    cnt2  <= cnt1;
    half2 <= half1;
  end

  // stage 3: ratio at least one million
  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else begin
      side.valid <= v2;
    end
    side.half <= half2;
    side.one  <= prod2 <= PROD_W'(cnt2);
    prod      <= prod2;
    cnt       <= PROD_W'(cnt2);
  end

endmodule

>>> src/nidf_log2.sv
// ---------------------------------------------------------------------------
// nidf_log2: pipelined fixed-point log2 lane
// Leading-zero normalization over four stages, then one fraction bit per two
// stages by squaring the mantissa from partial products of its 32-bit halves.
// ---------------------------------------------------------------------------
module nidf_log2 (
  input  logic                        clk,
  input  logic [nidf_pkg::PROD_W-1:0] x,
  output logic [nidf_pkg::LOG_W-1:0]  result
);
  import nidf_pkg::*;

  localparam int NB = PROD_W + POS_W;

  // one binary normalization step: shift by k when the top k bits are zero
  function automatic logic [NB-1:0] norm_step(input logic [PROD_W-1:0] v,
                                              input logic [POS_W-1:0] lz,
                                              input int k);
    logic [PROD_W-1:0] vs;
    logic [POS_W-1:0]  ls;
    vs = v;
    ls = lz;
    if ((v >> (PROD_W - k)) == '0) begin
      vs = v << k;
      ls = lz + POS_W'(k);
    end
    return {ls, vs};
  endfunction

  logic [NB-1:0] a0, a1, b0, b1, c0, c1, d0;
  logic [NB-1:0] n1, n2, n3;

  // normalization steps per stage: 64/32, 16/8, 4/2, 1
  always_comb begin
    a0 = norm_step(x, '0, 64);
    a1 = norm_step(a0[PROD_W-1:0], a0[NB-1:PROD_W], 32);
    b0 = norm_step(n1[PROD_W-1:0], n1[NB-1:PROD_W], 16);
    b1 = norm_step(b0[PROD_W-1:0], b0[NB-1:PROD_W], 8);
    c0 = norm_step(n2[PROD_W-1:0], n2[NB-1:PROD_W], 4);
    c1 = norm_step(c0[PROD_W-1:0], c0[NB-1:PROD_W], 2);
    d0 = norm_step(n3[PROD_W-1:0], n3[NB-1:PROD_W], 1);
  end

  logic [MANT_W-1:0]   m_s  [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] f_s  [LOG_FRAC+1];
  logic [POS_W-1:0]    p_s  [LOG_FRAC+1];
  logic [MANT_W-1:0]   ll_a [LOG_FRAC];
  logic [MANT_W-1:0]   lh_a [LOG_FRAC];
  logic [MANT_W-1:0]   hh_a [LOG_FRAC];
  logic [LOG_FRAC-1:0] f_a  [LOG_FRAC];
  logic [POS_W-1:0]    p_a  [LOG_FRAC];

  // normalization registers; last one yields mantissa and msb position
  always_ff @(posedge clk) begin
    n1     <= a1;
    n2     <= b1;
    n3     <= c1;
    m_s[0] <= d0[PROD_W-1 -: MANT_W];
    p_s[0] <= POS_W'(PROD_W - 1) - d0[NB-1:PROD_W];
    f_s[0] <= '0;
  end

  // squaring chain, two stages per fraction bit
  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_sq
    logic [2*MANT_W-1:0] sq;

    // partial products of the square
    always_ff @(posedge clk) begin
      ll_a[i] <= MANT_W'(m_s[i][HALF_W-1:0]) * MANT_W'(m_s[i][HALF_W-1:0]);
      lh_a[i] <= MANT_W'(m_s[i][HALF_W-1:0]) * MANT_W'(m_s[i][MANT_W-1:HALF_W]);
      hh_a[i] <= MANT_W'(m_s[i][MANT_W-1:HALF_W]) * MANT_W'(m_s[i][MANT_W-1:HALF_W]);
      f_a[i]  <= f_s[i];
      p_a[i]  <= p_s[i];
    end

    // sum, then renormalize and take one fraction bit
    always_comb begin
      sq = {hh_a[i], ll_a[i]} + ((2*MANT_W)'(lh_a[i]) << (HALF_W + 1));
    end

    always_ff @(posedge clk) begin
      f_s[i+1] <= {f_a[i][LOG_FRAC-2:0], sq[2*MANT_W-1]};
      p_s[i+1] <= p_a[i];
      if (sq[2*MANT_W-1]) begin
        m_s[i+1] <= sq[2*MANT_W-1 -: MANT_W];
      end else begin
        m_s[i+1] <= sq[2*MANT_W-2 -: MANT_W];
      end
    end
  end

  assign result = {p_s[LOG_FRAC], f_s[LOG_FRAC]};

endmodule

>>> src/nidf_div.sv
// ---------------------------------------------------------------------------
// nidf_div: log difference, pipelined division and rounding
// Clamps the log difference, divides it by twice log2(1e6) a few quotient
// bits per stage, and rounds into the significance result.
// ---------------------------------------------------------------------------
module nidf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  nidf_pkg::nidf_side_t       side,
  input  logic [nidf_pkg::LOG_W-1:0] la,
  input  logic [nidf_pkg::LOG_W-1:0] lc,
  output logic                       done,
  output logic [nidf_pkg::OUT_W-1:0] significance
);
  import nidf_pkg::*;

  logic [LOG_W-1:0] diff, lg;

  // clamped log difference
  always_comb begin
    diff = la - lc;
    lg   = (la > lc) ? diff : '0;
    if (lg > LOG_N) lg = LOG_N;
  end

  nidf_side_t       s_q [DIV_STAGES+1];
  logic [REM_W-1:0] r_q [DIV_STAGES+1];
  logic [QBITS-1:0] q_q [DIV_STAGES+1];

  // entry register of the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      s_q[0].valid <= 1'b0;
    end else begin
      s_q[0].valid <= side.valid;
    end
    s_q[0].half <= side.half;
    s_q[0].one  <= side.one;
    r_q[0]      <= REM_W'(lg);
    q_q[0]      <= '0;
  end

  // restoring division stages
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [REM_W-1:0] r;
    logic [QBITS-1:0] q;

    always_comb begin
      r = r_q[s];
      q = q_q[s];
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (s * DIV_STEPS + j < QBITS) begin
          r = r << 1;
          q = q << 1;
          if (r >= DIVISOR) begin
            r    = r - DIVISOR;
            q[0] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s_q[s+1].valid <= 1'b0;
      end else begin
        s_q[s+1].valid <= s_q[s].valid;
      end
      s_q[s+1].half <= s_q[s].half;
      s_q[s+1].one  <= s_q[s].one;
      r_q[s+1]      <= r;
      q_q[s+1]      <= q;
    end
  end

  logic [QBITS:0] q_inc;

  // round to nearest and pick the special cases
  assign q_inc = {1'b0, q_q[DIV_STAGES]} + (QBITS+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_q[DIV_STAGES].valid;
    end
    priority if (s_q[DIV_STAGES].half) begin
      significance <= HALF_FIX;
    end else if (s_q[DIV_STAGES].one) begin
      significance <= ONE_FIX;
    end else begin
      significance <= ONE_FIX - OUT_W'(q_inc >> 1);
    end
  end

endmodule

>>> src/normalized_idf_significance.sv
// ---------------------------------------------------------------------------
// normalized_idf_significance: normalized IDF of one term per cycle
// Pipeline: front end, two log2 lanes with the flags beside them, then divide and round.
// Throughput: one item per cycle.
// busy is held low; the receiver cannot stall, so the pipeline never waits.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
module normalized_idf_significance (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [nidf_pkg::IN_W-1:0]  doc_frequency,
  input  logic [nidf_pkg::IN_W-1:0]  doc_count,
  output logic                       done,
  output logic [nidf_pkg::OUT_W-1:0] significance
);
  import nidf_pkg::*;

  nidf_side_t        side_f;
  logic [PROD_W-1:0] prod, cnt;
  logic [LOG_W-1:0]  la, lc;
  nidf_side_t        side_d [LOG_LAT];

  // every cycle can take a transfer
  assign busy = 1'b0;

  nidf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .doc_frequency (doc_frequency),
    .doc_count     (doc_count),
    .side          (side_f),
    .prod          (prod),
    .cnt           (cnt)
  );

  nidf_log2 u_log_prod (
    .clk    (clk),
    .x      (prod),
    .result (la)
  );

  nidf_log2 u_log_cnt (
    .clk    (clk),
    .x      (cnt),
    .result (lc)
  );

  // flags travel beside the log lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LOG_LAT; k++) side_d[k].valid <= 1'b0;
    end else begin
      side_d[0].valid <= side_f.valid;
      for (int k = 1; k < LOG_LAT; k++) side_d[k].valid <= side_d[k-1].valid;
    end
    side_d[0].half <= side_f.half;
    side_d[0].one  <= side_f.one;
    for (int k = 1; k < LOG_LAT; k++) begin
      side_d[k].half <= side_d[k-1].half;
      side_d[k].one  <= side_d[k-1].one;
    end
  end

  nidf_div u_div (
    .clk          (clk),
    .rst          (rst),
    .side         (side_d[LOG_LAT-1]),
    .la           (la),
    .lc           (lc),
    .done         (done),
    .significance (significance)
  );

endmodule

>>> verif/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for normalized_idf_significance
// Drives term statistics through the command interface, predicts each
// significance value with a bit-exact fixed-point model and checks every
// done strobe against the oldest pending prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import nidf_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 120;
  localparam logic [63:0] CORPUS = 64'd1000000;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [IN_W-1:0]     doc_frequency;
  logic [IN_W-1:0]     doc_count;
  logic                done;
  logic [OUT_W-1:0]    significance;

  logic [OUT_W-1:0]    pending_sig[$];
  int                  error_count;
  int                  sent_count;
  int                  checked_count;
  int                  cycle_count;
  int                  idle_pct;

  normalized_idf_significance dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .doc_frequency(doc_frequency),
    .doc_count(doc_count),
    .done(done),
    .significance(significance)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // log2 of a nonzero 128-bit value in Q.40
  function automatic logic [63:0] log2_q40(input logic [127:0] x);
    logic [6:0]   msb;
    logic [127:0] sh;
    logic [63:0]  m;
    logic [127:0] sq;
    logic [39:0]  frac;
    msb = '0;
    frac = '0;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) msb = 7'(i);
    end
    sh = x << (127 - msb);
    m = sh[127:64];
    for (int i = 0; i < 40; i++) begin
      sq = 128'(m) * 128'(m);
      frac = {frac[38:0], sq[127]};
      m = sq[127] ? sq[127:64] : sq[126:63];
    end
    return {24'(msb), frac};
  endfunction

  // expected significance of one term
  function automatic logic [OUT_W-1:0] idf_significance(input logic [63:0] freq,
                                                       input logic [63:0] count);
    logic [127:0] scaled;
    logic [63:0]  h;
    logic [63:0]  la;
    logic [63:0]  lc;
    logic [63:0]  lg;
    logic [64:0]  rem;
    logic [64:0]  d;
    logic [63:0]  q;
    logic [63:0]  one;
    one = 64'd1 << FRAC_BITS;
    if (count == 0 || freq >= count) return OUT_W'(one >> 1);
    scaled = 128'(freq) * 128'(CORPUS);
    if (scaled <= 128'(count)) return OUT_W'(one);
    h = log2_q40(128'(CORPUS));
    d = {h, 1'b0};
    la = log2_q40(scaled);
    lc = log2_q40(128'(count));
    lg = (la > lc) ? la - lc : 64'd0;
    if (lg > h) lg = h;
    rem = 65'(lg);
    q = '0;
    for (int i = 0; i <= FRAC_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q[0] = 1'b1;
      end
    end
    return OUT_W'(one - ((q + 64'd1) >> 1));
  endfunction

  // send one term, honoring the sender idle rate
  task automatic send_term(input logic [63:0] freq, input logic [63:0] count);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    doc_frequency <= freq;
    doc_count <= count;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_sig.insert(pending_sig.size(), idf_significance(freq, count));
    sent_count++;
  endtask

  task automatic release_bus();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random value with a random magnitude
  function automatic logic [63:0] rand_mag();
    int bits;
    bits = $urandom_range(64, 1);
    return rand64() >> (64 - bits);
  endfunction

  // extremes and special cases
  task automatic test_directed();
    send_term(64'd5, 64'd0);
    send_term(64'd0, 64'd0);
    send_term('1, 64'd0);
    send_term(64'd0, 64'd1);
    send_term(64'd0, '1);
    send_term(64'd7, 64'd7);
    send_term('1, '1);
    send_term('1, 64'd1);
    send_term(64'd1, 64'd1000000);
    send_term(64'd1, 64'd1000001);
    send_term(64'd1, 64'd999999);
    send_term(64'd1, 64'd2);
    send_term(64'd1, '1);
    send_term(64'd2, '1);
    send_term('1 - 1, '1);
    send_term(64'h0000_1000_0000_0000, '1);
    send_term(64'd3, 64'd10);
    send_term(64'd12345, 64'd9876543210);
    send_term(64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFE);
    send_term(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    release_bus();
  endtask

  // random terms, mostly with frequency below count
  task automatic test_random(input int n);
    logic [63:0] f;
    logic [63:0] c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: begin
          f = rand64();
          c = rand64();
        end
        1: begin
          f = rand_mag();
          c = f + $urandom_range(3);
        end
        default: begin
          c = rand_mag();
          f = (c == 0) ? 64'd0 : rand_mag() % c;
        end
      endcase
      send_term(f, c);
    end
    release_bus();
  endtask

  task automatic wait_drain();
    while (pending_sig.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    logic [OUT_W-1:0] exp_sig;
    if (!rst && done) begin
      if (pending_sig.size() == 0) begin
        $error("unexpected result transfer: significance=%0d", significance);
        error_count++;
      end else begin
        exp_sig = pending_sig.pop_front();
        checked_count++;
        if (significance !== exp_sig) begin
          $error("significance mismatch: expected %0d actual %0d", exp_sig, significance);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    sent_count = 0;
    checked_count = 0;
    cycle_count = 0;
    idle_pct = 23;
    rst = 1'b1;
    start = 1'b0;
    doc_frequency = '0;
    doc_count = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(180);
    idle_pct = 83;
    test_random(120);
    idle_pct = 0;
    test_random(250);
    wait_drain();
    $display("covered %0d terms (zero count, ratio clamps, full-width values), %0d checked",
             sent_count, checked_count);
    if (error_count == 0 && pending_sig.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
